>>> rtl/core/soacu_pkg.sv
package soacu_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned NUM_SEGS = 6;
  localparam int unsigned SEG_W    = 3;

  localparam logic [2:0] OP_INS  = 3'd0;
  localparam logic [2:0] OP_OUTS = 3'd1;
  localparam logic [2:0] OP_MOVS = 3'd2;
  localparam logic [2:0] OP_STOS = 3'd3;
  localparam logic [2:0] OP_CMPS = 3'd4;
  localparam logic [2:0] OP_LODS = 3'd5;
  localparam logic [2:0] OP_SCAS = 3'd6;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;

  localparam logic [1:0] REP_NONE = 2'd0;

  localparam logic [1:0] RC_DONE   = 2'd0;
  localparam logic [1:0] RC_REPEAT = 2'd1;
  localparam logic [1:0] RC_IF_EQ  = 2'd2;
  localparam logic [1:0] RC_IF_NE  = 2'd3;

  localparam logic [SEG_W-1:0] SEG_ES  = 3'd0;
  localparam logic [SEG_W-1:0] SEG_DS  = 3'd3;
  localparam logic [SEG_W-1:0] OVR_DEF = 3'd0;

  localparam logic [DATA_W-1:0] MASK_16 = 32'h0000_ffff;
  localparam logic [DATA_W-1:0] MASK_32 = 32'hffff_ffff;

  typedef struct packed {
    logic [2:0]        op;
    logic [1:0]        size_code;
    logic              addr16;
    logic [1:0]        rep_mode;
    logic [2:0]        seg_override;
    logic              direction;
    logic [1:0]        cpl;
    logic [1:0]        iopl;
    logic [DATA_W-1:0] src_index;
    logic [DATA_W-1:0] dst_index;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] port_reg;
  } req_t;

  typedef struct packed {
    logic              execute;
    logic              fault;
    logic [DATA_W-1:0] src_addr;
    logic [DATA_W-1:0] dst_addr;
    logic [PORT_W-1:0] port_addr;
    logic [DATA_W-1:0] new_src_index;
    logic [DATA_W-1:0] new_dst_index;
    logic [DATA_W-1:0] new_count;
    logic [1:0]        repeat_cond;
  } rsp_t;

  function automatic logic [DATA_W-1:0] advance_index(
    input logic [DATA_W-1:0] v,
    input logic [DATA_W-1:0] delta,
    input logic [DATA_W-1:0] mask
  );
    logic [DATA_W-1:0] sum;
    sum = v + delta;
    return (v & ~mask) | (sum & mask);
  endfunction

endpackage

>>> rtl/core/soacu_seg_regs.sv
module soacu_seg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [soacu_pkg::SEG_W-1:0]     cfg_index,
  input  logic [soacu_pkg::DATA_W-1:0]    cfg_wdata,
  input  logic [soacu_pkg::SEG_W-1:0]     src_ovr,
  output logic [soacu_pkg::DATA_W-1:0]    src_base,
  output logic [soacu_pkg::DATA_W-1:0]    es_base
);
  import soacu_pkg::*;

  logic [DATA_W-1:0]  base_r [NUM_SEGS];
  logic [SEG_W-1:0]   src_seg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SEGS; i++) begin
        base_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < SEG_W'(NUM_SEGS))) begin
      base_r[cfg_index] <= cfg_wdata;
    end
  end

  // override k selects segment k-1; no override or out of range falls back to ds
  always_comb begin
    if ((src_ovr == OVR_DEF) || (src_ovr > SEG_W'(NUM_SEGS))) begin
      src_seg = SEG_DS;
    end else begin
      src_seg = src_ovr - SEG_W'(1);
    end
  end

  assign src_base = base_r[src_seg];
  assign es_base  = base_r[SEG_ES];

endmodule

>>> rtl/core/soacu_calc.sv
module soacu_calc (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  input  soacu_pkg::req_t               req,
  input  logic [soacu_pkg::DATA_W-1:0]  src_base,
  input  logic [soacu_pkg::DATA_W-1:0]  es_base,
  output logic                          rsp_valid,
  output soacu_pkg::rsp_t               rsp
);
  import soacu_pkg::*;

  logic              rsp_valid_r;
  rsp_t              rsp_r;
  rsp_t              rsp_nxt;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] step;
  logic [DATA_W-1:0] delta;
  logic              uses_src;
  logic              uses_dst;
  logic              is_port;
  logic              is_cmp;
  logic              op_ok;
  logic              zero_cnt;

  always_comb begin
    mask = req.addr16 ? MASK_16 : MASK_32;
    case (req.size_code)
      SIZE_BYTE: step = DATA_W'(1);
      SIZE_WORD: step = DATA_W'(2);
      default:   step = DATA_W'(4);
    endcase
    delta    = req.direction ? (~step + DATA_W'(1)) : step;
    uses_src = (req.op inside {OP_OUTS, OP_MOVS, OP_CMPS, OP_LODS});
    uses_dst = (req.op inside {OP_INS, OP_MOVS, OP_STOS, OP_CMPS, OP_SCAS});
    is_port  = (req.op inside {OP_INS, OP_OUTS});
    is_cmp   = (req.op inside {OP_CMPS, OP_SCAS});
    op_ok    = (req.op <= OP_SCAS);
    zero_cnt = (req.rep_mode != REP_NONE) && ((req.count & mask) == '0);
  end

  always_comb begin
    rsp_nxt               = '0;
    rsp_nxt.new_src_index = req.src_index;
    rsp_nxt.new_dst_index = req.dst_index;
    rsp_nxt.new_count     = req.count;
    rsp_nxt.repeat_cond   = RC_DONE;
    if (op_ok) begin
      if (is_port && (req.cpl > req.iopl)) begin
        rsp_nxt.fault = 1'b1;
      end else begin
        if (uses_src) begin
          rsp_nxt.src_addr = (req.src_index & mask) + src_base;
        end
        if (uses_dst) begin
          rsp_nxt.dst_addr = (req.dst_index & mask) + es_base;
        end
        if (is_port) begin
          rsp_nxt.port_addr = req.port_reg[PORT_W-1:0];
        end
        if (!zero_cnt) begin
          rsp_nxt.execute = 1'b1;
          if (uses_src) begin
            rsp_nxt.new_src_index = advance_index(req.src_index, delta, mask);
          end
          if (uses_dst) begin
            rsp_nxt.new_dst_index = advance_index(req.dst_index, delta, mask);
          end
          if (req.rep_mode != REP_NONE) begin
            rsp_nxt.new_count = advance_index(req.count, MASK_32, mask);
            if ((rsp_nxt.new_count & mask) != '0) begin
              if (is_cmp) begin
                rsp_nxt.repeat_cond = req.rep_mode[0] ? RC_IF_EQ : RC_IF_NE;
              end else begin
                rsp_nxt.repeat_cond = RC_REPEAT;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_valid_r <= 1'b0;
    end else begin
      rsp_valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign rsp_valid = rsp_valid_r;
  assign rsp       = rsp_r;

endmodule

>>> rtl/core/string_op_address_count_unit.sv
// channel   direction  handshake              payload
// request   in         start, busy            in_op .. in_port_reg
// result    out        out_strobe (1 cycle)   out_execute .. out_repeat_cond
// config    in         cfg_we                 cfg_index, cfg_wdata
//
// One request per cycle; the result is registered twice after start (input register,
// then result register). busy is always low.
// Synchronous active-low reset clears valid bits and all segment bases to zero.
// The receiver cannot stall; out_strobe marks each result for one cycle.
module string_op_address_count_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_op,
  input  logic [1:0]                    in_size_code,
  input  logic                          in_addr16,
  input  logic [1:0]                    in_rep_mode,
  input  logic [2:0]                    in_seg_override,
  input  logic                          in_direction,
  input  logic [1:0]                    in_cpl,
  input  logic [1:0]                    in_iopl,
  input  logic [soacu_pkg::DATA_W-1:0]  in_src_index,
  input  logic [soacu_pkg::DATA_W-1:0]  in_dst_index,
  input  logic [soacu_pkg::DATA_W-1:0]  in_count,
  input  logic [soacu_pkg::DATA_W-1:0]  in_port_reg,
  input  logic                          cfg_we,
  input  logic [soacu_pkg::SEG_W-1:0]   cfg_index,
  input  logic [soacu_pkg::DATA_W-1:0]  cfg_wdata,
  output logic                          out_strobe,
  output logic                          out_execute,
  output logic                          out_fault,
  output logic [soacu_pkg::DATA_W-1:0]  out_src_addr,
  output logic [soacu_pkg::DATA_W-1:0]  out_dst_addr,
  output logic [soacu_pkg::PORT_W-1:0]  out_port_addr,
  output logic [soacu_pkg::DATA_W-1:0]  out_new_src_index,
  output logic [soacu_pkg::DATA_W-1:0]  out_new_dst_index,
  output logic [soacu_pkg::DATA_W-1:0]  out_new_count,
  output logic [1:0]                    out_repeat_cond
);
  import soacu_pkg::*;

  logic              req_valid_r;
  req_t              req_r;
  req_t              req_nxt;
  logic [DATA_W-1:0] src_base;
  logic [DATA_W-1:0] es_base;
  logic              rsp_valid;
  rsp_t              rsp;

  assign busy = 1'b0;

  always_comb begin
    req_nxt.op           = in_op;
    req_nxt.size_code    = in_size_code;
    req_nxt.addr16       = in_addr16;
    req_nxt.rep_mode     = in_rep_mode;
    req_nxt.seg_override = in_seg_override;
    req_nxt.direction    = in_direction;
    req_nxt.cpl          = in_cpl;
    req_nxt.iopl         = in_iopl;
    req_nxt.src_index    = in_src_index;
    req_nxt.dst_index    = in_dst_index;
    req_nxt.count        = in_count;
    req_nxt.port_reg     = in_port_reg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= req_nxt;
    end
  end

  soacu_seg_regs u_seg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .src_ovr   (req_r.seg_override),
    .src_base  (src_base),
    .es_base   (es_base)
  );

  soacu_calc u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid_r),
    .req       (req_r),
    .src_base  (src_base),
    .es_base   (es_base),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  assign out_strobe        = rsp_valid;
  assign out_execute       = rsp.execute;
  assign out_fault         = rsp.fault;
  assign out_src_addr      = rsp.src_addr;
  assign out_dst_addr      = rsp.dst_addr;
  assign out_port_addr     = rsp.port_addr;
  assign out_new_src_index = rsp.new_src_index;
  assign out_new_dst_index = rsp.new_dst_index;
  assign out_new_count     = rsp.new_count;
  assign out_repeat_cond   = rsp.repeat_cond;

endmodule

>>> rtl/core/soacu_checker.sv
module soacu_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          out_strobe,
  input  logic                          out_execute,
  input  logic                          out_fault,
  input  logic [soacu_pkg::DATA_W-1:0]  out_src_addr,
  input  logic [soacu_pkg::DATA_W-1:0]  out_dst_addr,
  input  logic [soacu_pkg::PORT_W-1:0]  out_port_addr,
  input  logic [1:0]                    out_repeat_cond
);
  import soacu_pkg::*;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_strobe)
    else $error("request not answered two cycles later");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 2))
    else $error("result without request");

  a_fault_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_fault) |-> (!out_execute && out_src_addr == '0 &&
      out_dst_addr == '0 && out_port_addr == '0 && out_repeat_cond == RC_DONE))
    else $error("fault result carries side effects");

  a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_execute) |-> (out_repeat_cond == RC_DONE))
    else $error("repeat requested without execution");

endmodule

bind string_op_address_count_unit soacu_checker u_soacu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_execute     (out_execute),
  .out_fault       (out_fault),
  .out_src_addr    (out_src_addr),
  .out_dst_addr    (out_dst_addr),
  .out_port_addr   (out_port_addr),
  .out_repeat_cond (out_repeat_cond)
);
